@@ sv/websocket_frame_deframer_macros.svh @@
// Assertion helpers used by the checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Checked only out of reset.
`define WSFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset too.
`define WSFD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/wsfd_pkg.sv @@
package wsfd_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 64;
  localparam int OUT_LEN_W  = 32;
  localparam int KEY_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  typedef logic [1:0] err_t;

  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_TOO_LONG = 2'd1;
  localparam err_t ERR_UNMASKED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_MASK = 1'b1;

  localparam logic [CFG_DATA_W-1:0] MAX_LEN_RST  = 32'd1024;
  localparam logic                  REQ_MASK_RST = 1'b1;

endpackage

@@ sv/wsfd_in_if.sv @@
interface wsfd_in_if;
  logic                       valid;
  logic                       ready;
  logic [wsfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ sv/wsfd_out_if.sv @@
interface wsfd_out_if;
  logic                           valid;
  logic                           ready;
  logic [wsfd_pkg::BYTE_W-1:0]    payload_byte;
  logic                           byte_valid;
  logic                           last_in_frame;
  logic [3:0]                     frame_opcode;
  logic                           final_fragment;
  logic [wsfd_pkg::OUT_LEN_W-1:0] frame_length;
  wsfd_pkg::err_t                 error_code;

  modport source (
    output valid, output payload_byte, output byte_valid, output last_in_frame,
    output frame_opcode, output final_fragment, output frame_length,
    output error_code, input ready
  );
  modport sink (
    input valid, input payload_byte, input byte_valid, input last_in_frame,
    input frame_opcode, input final_fragment, input frame_length,
    input error_code, output ready
  );
endinterface

@@ sv/websocket_frame_deframer.sv @@
// WebSocket receive-side deframer.
// in_ch carries the raw frame stream, one byte per transaction. out_ch
// carries at most one result per input byte: an unmasked payload byte
// (byte_valid 1), or, on the last header byte, an empty result for a
// zero-length frame or an error result for a rejected frame.
// cfg_we/cfg_idx/cfg_wdata write max_payload_length (index 0) and
// require_mask (index 1); write only while the block is idle.
// A byte accepted on in_ch reaches the output register through the input
// register, then the result register.
// Throughput: one byte per cycle unless stalled; each byte's header/length/
// key/XOR update is one pass of logic between the two registers.
// Stall: if out_ch.ready is low with a result waiting, the input register
// still fills once, then in_ch.ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, returns the
// parser to header byte zero and restores max_payload_length = 1024 and
// require_mask = 1.
module websocket_frame_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  wsfd_in_if.sink                             in_ch,
  wsfd_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [wsfd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [wsfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // config
  logic [wsfd_pkg::CFG_DATA_W-1:0] max_len_r;
  logic                            req_mask_r;

  // input register
  logic                        s1_valid_r;
  logic [wsfd_pkg::BYTE_W-1:0] s1_byte_r;

  // parser state
  logic [2:0]                  phase_r, phase_nxt;
  logic [2:0]                  hcnt_r, hcnt_nxt;
  logic [wsfd_pkg::LEN_W-1:0]  plen_r, plen_nxt;
  logic [wsfd_pkg::LEN_W-1:0]  pcnt_r, pcnt_nxt;
  logic [wsfd_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic                        mask_r, mask_nxt;
  logic [3:0]                  opc_r, opc_nxt;
  logic                        fin_r, fin_nxt;
  logic                        disc_r, disc_nxt;

  // result register
  logic                           out_valid_r;
  logic [wsfd_pkg::BYTE_W-1:0]    res_byte_r, res_byte_nxt;
  logic                           res_bvalid_r, res_bvalid_nxt;
  logic                           res_last_r, res_last_nxt;
  logic [3:0]                     res_opc_r;
  logic                           res_fin_r;
  logic [wsfd_pkg::OUT_LEN_W-1:0] res_len_r, res_len_nxt;
  wsfd_pkg::err_t                 res_err_r, res_err_nxt;

  logic                        advance;
  logic                        emit;
  logic                        hdr_fin;
  logic                        too_long;
  logic                        unmasked;
  logic                        data_last;
  logic [6:0]                  len_code;
  logic [wsfd_pkg::BYTE_W-1:0] key_byte;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign len_code     = s1_byte_r[6:0];

  always_comb begin
    case (pcnt_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    hcnt_nxt       = hcnt_r;
    plen_nxt       = plen_r;
    pcnt_nxt       = pcnt_r;
    key_nxt        = key_r;
    mask_nxt       = mask_r;
    opc_nxt        = opc_r;
    fin_nxt        = fin_r;
    disc_nxt       = disc_r;
    hdr_fin        = 1'b0;
    emit           = 1'b0;
    data_last      = 1'b0;
    res_byte_nxt   = '0;
    res_bvalid_nxt = 1'b0;
    res_last_nxt   = 1'b0;
    res_err_nxt    = wsfd_pkg::ERR_NONE;

    unique case (phase_r)
      PH_HDR1: begin
        mask_nxt = s1_byte_r[7];
        plen_nxt = '0;
        if (len_code == LEN_CODE_16) begin
          hcnt_nxt  = 3'd2;
          phase_nxt = PH_EXT;
        end else if (len_code == LEN_CODE_64) begin
          hcnt_nxt  = 3'd0; // eight bytes, counter wraps
          phase_nxt = PH_EXT;
        end else begin
          plen_nxt = {{(wsfd_pkg::LEN_W-7){1'b0}}, len_code};
          if (s1_byte_r[7]) begin
            phase_nxt = PH_KEY;
            hcnt_nxt  = 3'd4;
          end else begin
            hdr_fin = 1'b1;
          end
        end
      end
      PH_EXT: begin
        plen_nxt = {plen_r[wsfd_pkg::LEN_W-9:0], s1_byte_r};
        hcnt_nxt = hcnt_r - 3'd1;
        if (hcnt_nxt == 3'd0) begin
          if (mask_r) begin
            phase_nxt = PH_KEY;
            hcnt_nxt  = 3'd4;
          end else begin
            hdr_fin = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_nxt  = {key_r[wsfd_pkg::KEY_W-9:0], s1_byte_r};
        hcnt_nxt = hcnt_r - 3'd1;
        if (hcnt_nxt == 3'd0) begin
          hdr_fin = 1'b1;
        end
      end
      PH_DATA: begin
        pcnt_nxt  = pcnt_r + 64'd1;
        data_last = (pcnt_nxt >= plen_r);
        if (data_last) begin
          phase_nxt = PH_HDR0;
        end
        if (disc_r) begin
          if (data_last) begin
            disc_nxt = 1'b0;
          end
        end else begin
          emit           = 1'b1;
          res_byte_nxt   = s1_byte_r ^ key_byte;
          res_bvalid_nxt = 1'b1;
          res_last_nxt   = data_last;
        end
      end
      default: begin
        fin_nxt   = s1_byte_r[7];
        opc_nxt   = s1_byte_r[3:0];
        key_nxt   = '0;
        mask_nxt  = 1'b0;
        plen_nxt  = '0;
        pcnt_nxt  = '0;
        hcnt_nxt  = 3'd0;
        disc_nxt  = 1'b0;
        phase_nxt = PH_HDR1;
      end
    endcase

    too_long = (|plen_nxt[wsfd_pkg::LEN_W-1:wsfd_pkg::OUT_LEN_W]) ||
               (plen_nxt[wsfd_pkg::OUT_LEN_W-1:0] > max_len_r);
    unmasked = !mask_nxt && req_mask_r;

    if (hdr_fin) begin
      pcnt_nxt = '0;
      if (too_long || unmasked) begin
        emit         = 1'b1;
        res_last_nxt = 1'b1;
        res_err_nxt  = too_long ? wsfd_pkg::ERR_TOO_LONG : wsfd_pkg::ERR_UNMASKED;
        if (plen_nxt != '0) begin
          disc_nxt  = 1'b1;
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_HDR0;
        end
      end else begin
        disc_nxt = 1'b0;
        if (plen_nxt == '0) begin
          emit         = 1'b1;
          res_last_nxt = 1'b1;
          phase_nxt    = PH_HDR0;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
    end
  end

  assign res_len_nxt = (|plen_nxt[wsfd_pkg::LEN_W-1:wsfd_pkg::OUT_LEN_W]) ?
                       {wsfd_pkg::OUT_LEN_W{1'b1}} :
                       plen_nxt[wsfd_pkg::OUT_LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= wsfd_pkg::MAX_LEN_RST;
      req_mask_r <= wsfd_pkg::REQ_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        wsfd_pkg::CFG_MAX_LEN:  max_len_r  <= cfg_wdata;
        wsfd_pkg::CFG_REQ_MASK: req_mask_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      hcnt_r  <= 3'd0;
      plen_r  <= '0;
      pcnt_r  <= '0;
      key_r   <= '0;
      mask_r  <= 1'b0;
      opc_r   <= 4'd0;
      fin_r   <= 1'b0;
      disc_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      plen_r  <= plen_nxt;
      pcnt_r  <= pcnt_nxt;
      key_r   <= key_nxt;
      mask_r  <= mask_nxt;
      opc_r   <= opc_nxt;
      fin_r   <= fin_nxt;
      disc_r  <= disc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_byte_r   <= res_byte_nxt;
      res_bvalid_r <= res_bvalid_nxt;
      res_last_r   <= res_last_nxt;
      res_opc_r    <= opc_r;
      res_fin_r    <= fin_r;
      res_len_r    <= res_len_nxt;
      res_err_r    <= res_err_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.payload_byte   = res_byte_r;
  assign out_ch.byte_valid     = res_bvalid_r;
  assign out_ch.last_in_frame  = res_last_r;
  assign out_ch.frame_opcode   = res_opc_r;
  assign out_ch.final_fragment = res_fin_r;
  assign out_ch.frame_length   = res_len_r;
  assign out_ch.error_code     = res_err_r;

endmodule

@@ sv/wsfd_checker.sv @@
`include "websocket_frame_deframer_macros.svh"

module wsfd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [wsfd_pkg::BYTE_W-1:0]    payload_byte,
  input logic                           byte_valid,
  input logic                           last_in_frame,
  input logic [3:0]                     frame_opcode,
  input logic                           final_fragment,
  input logic [wsfd_pkg::OUT_LEN_W-1:0] frame_length,
  input wsfd_pkg::err_t                 error_code
);

  logic                                        stalled;
  logic                                        data_out;
  logic                                        empty_out;
  logic [wsfd_pkg::BYTE_W+wsfd_pkg::OUT_LEN_W+8:0] res_bits;

  assign stalled   = out_valid && !out_ready;
  assign data_out  = out_valid && byte_valid;
  assign empty_out = out_valid && !byte_valid;
  assign res_bits  = {payload_byte, byte_valid, last_in_frame, frame_opcode,
                      final_fragment, frame_length, error_code};

  `WSFD_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid && in_ready), "not empty after reset")

  `WSFD_ASSERT(a_out_hold, stalled |=> (out_valid && $stable(res_bits)), "stalled result changed")

  `WSFD_ASSERT(a_data_no_err, data_out |-> (error_code == wsfd_pkg::ERR_NONE), "data with error")

  `WSFD_ASSERT(a_empty_is_last, empty_out |-> (last_in_frame && payload_byte == '0), "empty not final")

  `WSFD_ASSERT(a_err_code, out_valid |-> (error_code <= wsfd_pkg::ERR_UNMASKED), "bad error code")

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .payload_byte   (out_ch.payload_byte),
  .byte_valid     (out_ch.byte_valid),
  .last_in_frame  (out_ch.last_in_frame),
  .frame_opcode   (out_ch.frame_opcode),
  .final_fragment (out_ch.final_fragment),
  .frame_length   (out_ch.frame_length),
  .error_code     (out_ch.error_code)
);
